FILE: src/ffa_pkg.sv
// package for the first-fit arena allocator
// constants, types and the sequencer state enum; no dependencies
package ffa_pkg;
   localparam int unsigned ARENA_BYTES_DEF = 1048576;
   localparam int unsigned BLOCK_BYTES_DEF = 512;
   localparam int unsigned FREE_SLOTS_DEF  = 256;

   localparam int OFFSET_W = 20;
   localparam int LENGTH_W = 21;
   localparam int WIDE_W   = 32;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ARD,
      ST_ACHK,
      ST_FRD,
      ST_FCHK,
      ST_MRD,
      ST_MCHK,
      ST_LRD,
      ST_LWR,
      ST_OUT
   } state_type;
endpackage

FILE: src/ffa_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/first_fit_arena_allocator_unit.sv
// first-fit arena allocator with coalescing free list, top level
// depends on ffa_pkg and ffa_ram (two slot memories: start and size)
//
// channel | dir | tdata fields (low bit up)                          | tuser
// req     | in  | operation[0], region_offset[20:1], region_length[41:21] | -
// rsp     | out | granted_offset[20:0]                                 | -
//
// one request at a time; an allocate scans slots for a first fit or bumps, then grants
// a free scans slots; a merging free rescans once and moves the last slot in
// rounding masks for a power-of-two block size, else subtracts one block at a time
// the scan loop is set by the registered read data of the slot memories
// reset is synchronous and clears slot count, bump pointer and the sequencer
// slot memories need no clearing; only entries below the count are read
// req_tready is low while a request is in work or a result waits on rsp
module first_fit_arena_allocator_unit #(
   parameter int unsigned ARENA_BYTES = ffa_pkg::ARENA_BYTES_DEF,
   parameter int unsigned BLOCK_BYTES = ffa_pkg::BLOCK_BYTES_DEF,
   parameter int unsigned FREE_SLOTS  = ffa_pkg::FREE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // operation, region_offset, region_length, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // granted_offset, zero pad
);
   localparam int AW = $clog2(FREE_SLOTS);
   localparam int CW = $clog2(FREE_SLOTS + 1);
   localparam int W  = ffa_pkg::WIDE_W;
   localparam logic [W-1:0] ARENA_W = W'(ARENA_BYTES);
   localparam logic [W-1:0] BLK_W   = W'(BLOCK_BYTES);
   localparam logic [W-1:0] BLK_M1  = W'(BLOCK_BYTES - 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(FREE_SLOTS);
   localparam bit BLK_POW2 = (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0;

   ffa_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  bump_ff, bump_in;
   logic          op_ff, op_in;
   logic [W-1:0]  off_ff, off_in;
   logic [W-1:0]  len_ff, len_in;      // raw plus block-1, then rounded length
   logic [W-1:0]  quot_ff, quot_in;    // rounding by repeated subtract when not pow2
   logic [CW-1:0] idx_ff, idx_in;      // scan index
   logic [CW-1:0] hit_ff, hit_in;      // slot that absorbed the free
   logic [W-1:0]  hs_ff, hs_in;        // hit slot start
   logic [W-1:0]  hz_ff, hz_in;        // hit slot size (after merge)
   logic [CW-1:0] rm_ff, rm_in;        // slot to refill from last
   logic [W-1:0]  out_ff, out_in;

   logic            we;
   logic [AW-1:0]   wa, ra;
   logic [ffa_pkg::OFFSET_W-1:0] wd_s, rd_s;
   logic [ffa_pkg::LENGTH_W-1:0] wd_z, rd_z;
   logic [W-1:0]    s_w, z_w;

   ffa_ram #(.WIDTH(ffa_pkg::OFFSET_W), .DEPTH(FREE_SLOTS)) u_start (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd_s),
      .rd_addr(ra), .rd_data(rd_s));
   ffa_ram #(.WIDTH(ffa_pkg::LENGTH_W), .DEPTH(FREE_SLOTS)) u_size (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd_z),
      .rd_addr(ra), .rd_data(rd_z));

   assign s_w = W'(rd_s);
   assign z_w = W'(rd_z);

   assign req_tready = (state_ff == ffa_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == ffa_pkg::ST_OUT);
   assign rsp_tdata  = {3'b000, out_ff[ffa_pkg::LENGTH_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::ST_IDLE;
         count_ff <= '0;
         bump_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bump_ff  <= bump_in;
      end
      op_ff   <= op_in;
      off_ff  <= off_in;
      len_ff  <= len_in;
      quot_ff <= quot_in;
      idx_ff  <= idx_in;
      hit_ff  <= hit_in;
      hs_ff   <= hs_in;
      hz_ff   <= hz_in;
      rm_ff   <= rm_in;
      out_ff  <= out_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      bump_in  = bump_ff;
      op_in    = op_ff;
      off_in   = off_ff;
      len_in   = len_ff;
      quot_in  = quot_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      hs_in    = hs_ff;
      hz_in    = hz_ff;
      rm_in    = rm_ff;
      out_in   = out_ff;
      we   = 1'b0;
      wa   = idx_ff[AW-1:0];
      wd_s = '0;
      wd_z = '0;
      ra   = idx_ff[AW-1:0];
      case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tdata[0];
               off_in  = W'(req_tdata[20:1]);
               len_in  = W'(req_tdata[41:21]) + BLK_M1;
               quot_in = '0;
               idx_in  = '0;
               state_in = ffa_pkg::ST_PREP;
            end
         end
         ffa_pkg::ST_PREP: begin
            // round up: mask for a power of two, else subtract one block a cycle
            if (BLK_POW2) begin
               len_in = len_ff & ~BLK_M1;
               quot_in = '0;
            end else if (len_ff >= BLK_W) begin
               len_in = len_ff - BLK_W;
               quot_in = quot_ff + BLK_W;
            end
            if (BLK_POW2 || len_ff < BLK_W) begin
               if (!BLK_POW2) len_in = quot_ff;
               if (op_ff == ffa_pkg::OP_ALLOC) begin
                  if (len_in == '0) begin
                     out_in = ARENA_W;
                     state_in = ffa_pkg::ST_OUT;
                  end else begin
                     state_in = ffa_pkg::ST_ARD;
                  end
               end else begin
                  if (off_ff >= ARENA_W || len_in == '0 || off_ff + len_in > ARENA_W)
                     state_in = ffa_pkg::ST_IDLE;
                  else
                     state_in = ffa_pkg::ST_FRD;
               end
            end
         end
         ffa_pkg::ST_ARD: begin
            if (idx_ff < count_ff) begin
               state_in = ffa_pkg::ST_ACHK;
            end else if (bump_ff + len_ff > ARENA_W) begin
               out_in = ARENA_W;
               state_in = ffa_pkg::ST_OUT;
            end else begin
               out_in = bump_ff;
               bump_in = bump_ff + len_ff;
               state_in = ffa_pkg::ST_OUT;
            end
         end
         ffa_pkg::ST_ACHK: begin
            if (z_w >= len_ff) begin
               out_in = s_w;
               if (z_w > len_ff) begin
                  we = 1'b1;
                  wd_s = ffa_pkg::OFFSET_W'(s_w + len_ff);
                  wd_z = ffa_pkg::LENGTH_W'(z_w - len_ff);
                  state_in = ffa_pkg::ST_OUT;
               end else begin
                  rm_in = idx_ff;
                  count_in = count_ff - 1'b1;
                  idx_in = count_ff - 1'b1;
                  state_in = ffa_pkg::ST_LRD;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ffa_pkg::ST_ARD;
            end
         end
         ffa_pkg::ST_FRD: begin
            if (idx_ff < count_ff) begin
               state_in = ffa_pkg::ST_FCHK;
            end else begin
               if (count_ff < SLOTS_C) begin
                  we = 1'b1;
                  wa = count_ff[AW-1:0];
                  wd_s = ffa_pkg::OFFSET_W'(off_ff);
                  wd_z = ffa_pkg::LENGTH_W'(len_ff);
                  count_in = count_ff + 1'b1;
               end
               state_in = ffa_pkg::ST_IDLE;
            end
         end
         ffa_pkg::ST_FCHK: begin
            if (s_w + z_w == off_ff) begin
               we = 1'b1;
               wd_s = rd_s;
               wd_z = ffa_pkg::LENGTH_W'(z_w + len_ff);
               hit_in = idx_ff;
               hs_in = s_w;
               hz_in = z_w + len_ff;
               idx_in = '0;
               state_in = ffa_pkg::ST_MRD;
            end else if (off_ff + len_ff == s_w) begin
               we = 1'b1;
               wd_s = ffa_pkg::OFFSET_W'(off_ff);
               wd_z = ffa_pkg::LENGTH_W'(z_w + len_ff);
               state_in = ffa_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ffa_pkg::ST_FRD;
            end
         end
         ffa_pkg::ST_MRD: begin
            if (idx_ff == hit_ff) begin
               idx_in = idx_ff + 1'b1;
            end else if (idx_ff < count_ff) begin
               state_in = ffa_pkg::ST_MCHK;
            end else begin
               state_in = ffa_pkg::ST_IDLE;
            end
         end
         ffa_pkg::ST_MCHK: begin
            if (hs_ff + hz_ff == s_w) begin
               // absorb this slot into the hit slot, then refill it from the last
               we = 1'b1;
               wa = hit_ff[AW-1:0];
               wd_s = ffa_pkg::OFFSET_W'(hs_ff);
               wd_z = ffa_pkg::LENGTH_W'(hz_ff + z_w);
               rm_in = idx_ff;
               count_in = count_ff - 1'b1;
               idx_in = count_ff - 1'b1;
               state_in = ffa_pkg::ST_LRD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ffa_pkg::ST_MRD;
            end
         end
         ffa_pkg::ST_LRD: begin
            // read address is the last slot; data arrives next cycle
            state_in = ffa_pkg::ST_LWR;
         end
         ffa_pkg::ST_LWR: begin
            // the last slot is read after the merge write, so it is already current
            we = 1'b1;
            wa = rm_ff[AW-1:0];
            wd_s = rd_s;
            wd_z = rd_z;
            state_in = (op_ff == ffa_pkg::OP_ALLOC) ? ffa_pkg::ST_OUT : ffa_pkg::ST_IDLE;
         end
         ffa_pkg::ST_OUT: begin
            if (rsp_tready) state_in = ffa_pkg::ST_IDLE;
         end
         default: state_in = ffa_pkg::ST_IDLE;
      endcase
   end
endmodule
